/* hw/rtl/ipv4_fragment_header_generator_top_defines.svh */
// ----------------------------------------------------------------------------
// IPv4 fragment header generator assertion macros
// Shared assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef IPV4_FRAGMENT_HEADER_GENERATOR_TOP_DEFINES_SVH
`define IPV4_FRAGMENT_HEADER_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication
`define IPV4FG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IPV4FG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ipv4fg_pkg.sv */
// ----------------------------------------------------------------------------
// IPv4 fragment header generator package
// Types and constants shared by the front end, job queue and back end.
// ----------------------------------------------------------------------------
package ipv4fg_pkg;

    typedef enum logic [1:0]
    {
        ST_FRAG    = 2'd0,
        ST_NOFRAG  = 2'd1,
        ST_TOOMANY = 2'd2
    } status_t;

    localparam logic [15:0] HDR_BYTES = 16'd20;
    localparam logic [15:0] MF_BIT    = 16'h2000;
    localparam logic [15:0] MTU_RESET = 16'd1500;
    localparam logic [15:0] CHUNK_MASK = 16'hfff8;

    localparam int unsigned REG_MTU = 0;

    localparam int unsigned IN_TDATA_W  = 176;
    localparam int unsigned OUT_TDATA_W = 88;
    localparam int unsigned BASE_W      = 19;

    typedef struct packed
    {
        status_t             kind;
        logic [15:0]         data;
        logic [15:0]         chunk;
        logic [BASE_W-1:0]   base;
    } job_t;

endpackage

/* hw/rtl/ipv4_fragment_header_generator_top.sv */
// ----------------------------------------------------------------------------
// IPv4 fragment header generator
// Turns an IPv4 header and packet length into one descriptor per fragment.
// ----------------------------------------------------------------------------
// A header transaction is accepted by the front end, which sizes and
// classifies it and hands a job to a two-entry queue, so new headers are
// accepted while earlier packets are still being split. The back end
// sequencer emits one fragment descriptor per cycle while the output is not
// stalled; a no-fragmentation or too-large result gives a single
// descriptor. The MTU register at address 0 should only be written while no
// packet is in flight.
module ipv4_fragment_header_generator_top
    import ipv4fg_pkg::*;
#(
    parameter int MAX_FRAGS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // APB configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // header in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // header_words_low, header_words_mid, header_words_high, packet_length
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // descriptors out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // fragment_index, total_length, flags_offset_word, header_checksum,
    // payload_offset, payload_length, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    // status
    output logic [1:0]             m_axis_tuser
);

    logic [15:0] mtu_reg;
    logic        reg_hit;
    logic        fq_valid, fq_ready, qb_valid, qb_ready;
    job_t        fq_job, qb_job;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == 1'(REG_MTU));
    assign prdata  = reg_hit ? {16'd0, mtu_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mtu_reg <= MTU_RESET;
        else if (psel && penable && pwrite && pready && reg_hit)
            mtu_reg <= pwdata[15:0];
    end

    ipv4fg_front #(.MAX_FRAGS(MAX_FRAGS)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mtu       (mtu_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    ipv4fg_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    ipv4fg_back #(.MAX_FRAGS(MAX_FRAGS)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (qb_valid),
        .job_ready     (qb_ready),
        .job           (qb_job),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* hw/rtl/ipv4fg_front.sv */
// ----------------------------------------------------------------------------
// IPv4 fragment front end
// Accepts a header transaction, sums the fixed header words, sizes the
// fragment payload and classifies the packet into a job for the back end.
// ----------------------------------------------------------------------------
module ipv4fg_front
    import ipv4fg_pkg::*;
#(
    parameter int MAX_FRAGS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [15:0]           mtu,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [IN_TDATA_W-1:0] in_data,
    output logic                  job_valid,
    input  logic                  job_ready,
    output job_t                  job
);

    localparam int CNT_W  = $clog2(MAX_FRAGS + 1);
    localparam int PROD_W = 16 + CNT_W;
    localparam logic [CNT_W-1:0] FRAG_CNT = CNT_W'(MAX_FRAGS);

    logic                s1_valid_reg, s1_valid_next;
    logic [BASE_W-1:0]   base_reg;
    logic [15:0]         data_reg;
    logic [15:0]         chunk_reg;
    logic [PROD_W-1:0]   limit_reg;
    logic                fits_reg;

    logic [63:0]         w_low, w_mid;
    logic [31:0]         w_high;
    logic [15:0]         plen, chunk_c, mtu_less;
    logic [BASE_W-1:0]   base_c;
    logic                accept;

    assign w_low  = in_data[63:0];
    assign w_mid  = in_data[127:64];
    assign w_high = in_data[159:128];
    assign plen   = in_data[175:160];

    assign base_c = BASE_W'(w_low[63:48]) + BASE_W'(w_low[31:16])
                  + BASE_W'(w_mid[63:48]) + BASE_W'(w_mid[31:16])
                  + BASE_W'(w_mid[15:0])  + BASE_W'(w_high[31:16])
                  + BASE_W'(w_high[15:0]);

    assign mtu_less = mtu - HDR_BYTES;
    assign chunk_c  = (mtu >= HDR_BYTES) ? (mtu_less & CHUNK_MASK) : 16'd0;

    assign in_ready  = !s1_valid_reg || job_ready;
    assign accept    = in_valid && in_ready;
    assign job_valid = s1_valid_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (job_ready)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_reg  <= base_c;
            data_reg  <= plen - HDR_BYTES;
            chunk_reg <= chunk_c;
            limit_reg <= PROD_W'(chunk_c) * PROD_W'(FRAG_CNT);
            fits_reg  <= (plen <= mtu) || (plen <= HDR_BYTES);
        end
    end

    always_comb
    begin
        job.data  = data_reg;
        job.chunk = chunk_reg;
        job.base  = base_reg;
        if (fits_reg)
            job.kind = ST_NOFRAG;
        else if (chunk_reg == 16'd0 || PROD_W'(data_reg) > limit_reg)
            job.kind = ST_TOOMANY;
        else
            job.kind = ST_FRAG;
    end

endmodule

/* hw/rtl/ipv4fg_queue.sv */
// ----------------------------------------------------------------------------
// IPv4 fragment job queue
// Two-entry queue of classified jobs between the front and back ends.
// ----------------------------------------------------------------------------
module ipv4fg_queue
    import ipv4fg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

/* hw/rtl/ipv4fg_back.sv */
// ----------------------------------------------------------------------------
// IPv4 fragment back end
// Walks a job one fragment per cycle while the output is not stalled, then
// finishes the header checksum in the output register stage.
// ----------------------------------------------------------------------------
module ipv4fg_back
    import ipv4fg_pkg::*;
#(
    parameter int MAX_FRAGS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_valid,
    output logic                   job_ready,
    input  job_t                   job,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    output logic [1:0]             m_axis_tuser
);

    localparam int IDX_W = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;

    // sequencer
    logic             cur_valid_reg, cur_valid_next;
    job_t             cur_reg;
    logic [15:0]      off_reg;
    logic [IDX_W-1:0] idx_reg;

    // fragment stage
    logic              frag_valid_reg, frag_valid_next;
    status_t           frag_status_reg;
    logic [3:0]        frag_idx_reg;
    logic [15:0]       frag_tl_reg, frag_fo_reg, frag_off_reg, frag_pl_reg;
    logic              frag_last_reg;
    logic [BASE_W-1:0] frag_base_reg;

    // output stage
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_last_reg;
    logic [1:0]             out_user_reg;

    logic             is_frag, more, seq_last, seq_fire, frag_load, out_load;
    logic [15:0]      rem, pl, tl, fo;
    logic [IDX_W+3:0] idx_ext;
    logic [19:0]      sum;
    logic [16:0]      fold1;
    logic [15:0]      fold2, csum;

    assign is_frag  = (cur_reg.kind == ST_FRAG);
    assign rem      = cur_reg.data - off_reg;
    assign more     = is_frag && (rem > cur_reg.chunk);
    assign pl       = more ? cur_reg.chunk : rem;
    assign tl       = pl + HDR_BYTES;
    assign fo       = (more ? MF_BIT : 16'd0) | {3'b000, off_reg[15:3]};
    assign seq_last = !more;
    assign idx_ext  = {4'b0000, idx_reg};

    assign out_load  = frag_valid_reg && (!out_valid_reg || m_axis_tready);
    assign frag_load = !frag_valid_reg || out_load;
    assign seq_fire  = cur_valid_reg && frag_load;
    assign job_ready = !cur_valid_reg || (seq_fire && seq_last);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        if (job_ready)
            cur_valid_next = job_valid;
        frag_valid_next = frag_load ? cur_valid_reg : frag_valid_reg;
        out_valid_next  = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            frag_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            off_reg        <= 16'd0;
            idx_reg        <= '0;
        end
        else
        begin
            cur_valid_reg  <= cur_valid_next;
            frag_valid_reg <= frag_valid_next;
            out_valid_reg  <= out_valid_next;
            if (job_ready)
            begin
                off_reg <= 16'd0;
                idx_reg <= '0;
            end
            else if (seq_fire)
            begin
                off_reg <= off_reg + pl;
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_ready && job_valid)
            cur_reg <= job;
    end

    always_ff @(posedge clk)
    begin
        if (seq_fire)
        begin
            frag_status_reg <= cur_reg.kind;
            frag_last_reg   <= seq_last;
            frag_base_reg   <= cur_reg.base;
            if (is_frag)
            begin
                frag_idx_reg <= idx_ext[3:0];
                frag_tl_reg  <= tl;
                frag_fo_reg  <= fo;
                frag_off_reg <= off_reg;
                frag_pl_reg  <= pl;
            end
            else
            begin
                frag_idx_reg <= 4'd0;
                frag_tl_reg  <= 16'd0;
                frag_fo_reg  <= 16'd0;
                frag_off_reg <= 16'd0;
                frag_pl_reg  <= 16'd0;
            end
        end
    end

    // ones-complement sum, checksum word taken as zero
    assign sum   = 20'(frag_base_reg) + 20'(frag_tl_reg) + 20'(frag_fo_reg);
    assign fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);
    assign csum  = (frag_status_reg == ST_FRAG) ? ~fold2 : 16'd0;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {4'b0000, frag_pl_reg, frag_off_reg, csum,
                             frag_fo_reg, frag_tl_reg, frag_idx_reg};
            out_last_reg <= frag_last_reg;
            out_user_reg <= frag_status_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

/* hw/rtl/ipv4fg_checker.sv */
// ----------------------------------------------------------------------------
// IPv4 fragment header generator port checker
// Watches the descriptor output port of the top level.
// ----------------------------------------------------------------------------
`include "ipv4_fragment_header_generator_top_defines.svh"

module ipv4fg_checker
    import ipv4fg_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast,
    input logic [1:0]             m_axis_tuser
);

    logic                   frag_out, lone_out, lone_ok, tl_ok, stalled;
    logic [15:0]            tl_out, pl_out;
    logic [OUT_TDATA_W+2:0] out_bus;

    assign frag_out = m_axis_tvalid && (m_axis_tuser == ST_FRAG);
    assign lone_out = m_axis_tvalid && (m_axis_tuser != ST_FRAG);
    assign lone_ok  = m_axis_tlast && (m_axis_tdata == '0)
                   && (m_axis_tuser == ST_NOFRAG || m_axis_tuser == ST_TOOMANY);
    assign tl_out   = m_axis_tdata[19:4];
    assign pl_out   = m_axis_tdata[83:68];
    assign tl_ok    = (tl_out == pl_out + HDR_BYTES);
    assign stalled  = m_axis_tvalid && !m_axis_tready;
    assign out_bus  = {m_axis_tuser, m_axis_tlast, m_axis_tdata};

    `IPV4FG_ASSERT_NOW(a_single_result, lone_out, lone_ok, "bad status result")
    `IPV4FG_ASSERT_NOW(a_total_len, frag_out, tl_ok, "bad total length")
    `IPV4FG_ASSERT_NOW(a_mf_bit, frag_out, m_axis_tdata[33] == !m_axis_tlast, "bad MF bit")
    `IPV4FG_ASSERT_NEXT(a_hold, stalled, m_axis_tvalid && $stable(out_bus), "stall not held")

endmodule

bind ipv4_fragment_header_generator_top ipv4fg_checker u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// IPv4 fragment header generator testbench
// Sends IPv4 headers with packet lengths around each MTU setting and checks
// every fragment descriptor against a local predictor of the splitting
// rules, under random valid/ready gaps, one long output stall and several
// MTU values, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
    import ipv4fg_pkg::*;

    localparam int MAX_FRAGS    = 16;
    localparam int STALL_CYCLES = 300;
    localparam int SETTLE       = 20;
    localparam int LIMIT        = 400000;

    typedef enum
    {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } hdr_fill_t;

    typedef struct
    {
        status_t     status;
        logic [3:0]  index;
        logic [15:0] total_len;
        logic [15:0] flags_off;
        logic [15:0] csum;
        logic [15:0] pay_off;
        logic [15:0] pay_len;
        logic        last;
    } frag_desc_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic [1:0]             m_axis_tuser;

    logic [15:0]           mtu_now = MTU_RESET;
    frag_desc_t            frag_expect[$];
    logic [IN_TDATA_W-1:0] hdr_pending[$];
    int                    mismatches = 0;
    int                    cycles = 0;
    logic                  tx_idle_on = 1'b1;
    logic                  rx_idle_on = 1'b1;
    logic                  stall_armed = 1'b0;
    int                    stall_count = 0;

    ipv4_fragment_header_generator_top #(
        .MAX_FRAGS(MAX_FRAGS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic void push_single(status_t st);
        frag_desc_t fd;
        fd = '{status: st, index: '0, total_len: '0, flags_off: '0, csum: '0,
               pay_off: '0, pay_len: '0, last: 1'b1};
        frag_expect.push_back(fd);
    endfunction

    // splits one header transaction into its expected fragment descriptors
    function automatic void predict_fragments(logic [IN_TDATA_W-1:0] d);
        int unsigned plen;
        int unsigned chunk;
        int unsigned data;
        int unsigned need;
        int unsigned off;
        int unsigned pl;
        int unsigned sum;
        logic [15:0] w[10];
        logic        more;
        frag_desc_t  fd;
        plen = d[175:160];
        if (plen <= mtu_now || plen <= HDR_BYTES)
        begin
            push_single(ST_NOFRAG);
            return;
        end
        chunk = (mtu_now >= HDR_BYTES) ? ((mtu_now - HDR_BYTES) & CHUNK_MASK) : 0;
        data = plen - HDR_BYTES;
        if (chunk == 0)
        begin
            push_single(ST_TOOMANY);
            return;
        end
        need = (data + chunk - 1) / chunk;
        if (need > MAX_FRAGS)
        begin
            push_single(ST_TOOMANY);
            return;
        end
        for (int k = 0; k < 4; k++)
        begin
            w[k] = d[63 - 16*k -: 16];
            w[4 + k] = d[127 - 16*k -: 16];
        end
        w[8] = d[159:144];
        w[9] = d[143:128];
        w[5] = '0;
        off = 0;
        for (int unsigned k = 0; k < need; k++)
        begin
            more = (data - off) > chunk;
            pl = more ? chunk : (data - off);
            w[1] = 16'(pl + HDR_BYTES);
            w[3] = 16'((off >> 3) & 32'h1fff) | (more ? MF_BIT : 16'd0);
            sum = 0;
            for (int i = 0; i < 10; i++)
                sum += w[i];
            while (sum >> 16)
                sum = (sum & 32'hffff) + (sum >> 16);
            fd.status = ST_FRAG;
            fd.index = 4'(k);
            fd.total_len = w[1];
            fd.flags_off = w[3];
            fd.csum = ~sum[15:0];
            fd.pay_off = 16'(off);
            fd.pay_len = 16'(pl);
            fd.last = (k + 1 == need);
            frag_expect.push_back(fd);
            off += pl;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (act !== exp)
        begin
            $display("%0t: %s expected %h got %h", $time, name, exp, act);
            mismatches++;
        end
    endfunction

    function automatic void push_header(int unsigned plen, hdr_fill_t fill);
        logic [159:0] hdr;
        case (fill)
            FILL_ZERO: hdr = '0;
            FILL_ONES: hdr = '1;
            default:   hdr = {$urandom, $urandom, $urandom, $urandom, $urandom};
        endcase
        hdr_pending.push_back({16'(plen), hdr});
    endfunction

    // packet length aimed mostly at the fragmenting range of the current MTU
    function automatic int unsigned pick_length();
        int unsigned chunk;
        int unsigned maxlen;
        int unsigned r;
        chunk = (mtu_now >= HDR_BYTES) ? ((mtu_now - HDR_BYTES) & CHUNK_MASK) : 0;
        maxlen = HDR_BYTES + chunk * MAX_FRAGS;
        if (maxlen > 65535)
            maxlen = 65535;
        r = $urandom_range(99);
        if (r < 65 && mtu_now < maxlen)
            return $urandom_range(maxlen, mtu_now + 1);
        if (r < 78)
            return $urandom_range((mtu_now < HDR_BYTES) ? HDR_BYTES : mtu_now, HDR_BYTES);
        if (r < 90 && maxlen < 65535)
            return $urandom_range(65535, maxlen + 1);
        return $urandom_range(65535, HDR_BYTES);
    endfunction

    // header driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_fragments(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (hdr_pending.size() != 0 && !(tx_idle_on && $urandom_range(99) < 25))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= hdr_pending.pop_front();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // descriptor monitor
    always @(posedge clk)
    begin
        frag_desc_t fd;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (frag_expect.size() == 0)
            begin
                $display("%0t: unexpected descriptor, expected none got %h", $time,
                         m_axis_tdata);
                mismatches++;
            end
            else
            begin
                fd = frag_expect.pop_front();
                check_field("status", fd.status, m_axis_tuser);
                check_field("fragment_index", fd.index, m_axis_tdata[3:0]);
                check_field("total_length", fd.total_len, m_axis_tdata[19:4]);
                check_field("flags_offset_word", fd.flags_off, m_axis_tdata[35:20]);
                check_field("header_checksum", fd.csum, m_axis_tdata[51:36]);
                check_field("payload_offset", fd.pay_off, m_axis_tdata[67:52]);
                check_field("payload_length", fd.pay_len, m_axis_tdata[83:68]);
                check_field("pad", 0, m_axis_tdata[87:84]);
                check_field("last", fd.last, m_axis_tlast);
            end
        end
        if (stall_armed && stall_count < STALL_CYCLES)
        begin
            m_axis_tready <= 1'b0;
            stall_count++;
        end
        else if (rx_idle_on)
        begin
            m_axis_tready <= ($urandom_range(99) >= 25);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("ipv4_fragment_header_generator_top: mismatch");
            $finish;
        end
    end

    // sampled between edges so that the driver's updates are settled
    task automatic wait_drained();
        while (hdr_pending.size() != 0 || s_axis_tvalid || frag_expect.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_mtu_read();
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 3'(REG_MTU * 4);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("mtu_bytes read", {16'd0, mtu_now}, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_mtu(logic [15:0] value);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(REG_MTU * 4);
        pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mtu_now = value;
        check_mtu_read();
    endtask

    // random headers, with a full drain halfway through
    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                wait_drained();
            push_header(pick_length(), FILL_RANDOM);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        check_mtu_read();

        // reset MTU of 1500: edges of the no-fragmentation and too-many limits
        push_header(20, FILL_RANDOM);
        push_header(21, FILL_ONES);
        push_header(1500, FILL_RANDOM);
        push_header(1501, FILL_RANDOM);
        push_header(1520, FILL_ZERO);
        push_header(2980, FILL_RANDOM);
        push_header(2981, FILL_ONES);
        push_header(23700, FILL_ONES);
        push_header(23701, FILL_RANDOM);
        push_header(65535, FILL_ONES);
        push_header(3000, FILL_ZERO);
        push_header(10000, FILL_ONES);
        run_random(40);

        // smallest MTU that leaves room for payload, no idling on either side
        set_mtu(16'd28);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        push_header(29, FILL_ONES);
        push_header(148, FILL_ONES);
        push_header(149, FILL_RANDOM);
        push_header(28, FILL_ZERO);
        run_random(40);

        // long output stall while headers keep coming
        set_mtu(16'd576);
        rx_idle_on = 1'b1;
        stall_armed = 1'b1;
        for (int i = 0; i < 45; i++)
            push_header($urandom_range(65535, 3000), FILL_RANDOM);
        wait_drained();
        tx_idle_on = 1'b1;
        run_random(20);

        set_mtu(16'hffff);
        push_header(65535, FILL_ONES);
        run_random(30);

        // no room for payload
        set_mtu(16'd24);
        push_header(24, FILL_RANDOM);
        push_header(25, FILL_RANDOM);
        push_header(20, FILL_ZERO);
        push_header(65535, FILL_ONES);
        run_random(30);

        for (int p = 0; p < 3; p++)
        begin
            set_mtu((p == 2) ? 16'($urandom_range(65535, 28)) : 16'($urandom_range(4000, 28)));
            run_random(32);
        end

        set_mtu(MTU_RESET);
        run_random(40);

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("ipv4_fragment_header_generator_top: match");
        else
            $display("ipv4_fragment_header_generator_top: mismatch");
        $finish;
    end

endmodule
